>>> rtl/pltm_pkg.sv
// Shared constants for the pulse low-time trimmed-mean core.
package pltm_pkg;

	// field widths fixed by the stream layout
	localparam int unsigned TIMEOUT_W  = 24;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned DUR_OUT_W  = 24;
	localparam int unsigned AVG_OUT_W  = 28;
	localparam int unsigned COUNT_W    = 4;
	localparam int unsigned S_TDATA_W  = 8;
	localparam int unsigned M_TDATA_W  = 64;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd10000000;
	localparam int unsigned          MIN_VALID     = 3;
	localparam int unsigned          FRAC_BITS     = 4;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_AVG_OK   = 3'd0;
	localparam status_t ST_TOO_FEW  = 3'd1;
	localparam status_t ST_TO_HIGH  = 3'd2;
	localparam status_t ST_TO_FALL  = 3'd3;
	localparam status_t ST_TO_LOW   = 3'd4;

	typedef logic [1:0] phase_t;

	localparam phase_t PH_WAIT_HIGH = 2'd0;
	localparam phase_t PH_WAIT_FALL = 2'd1;
	localparam phase_t PH_COUNT_LOW = 2'd2;

endpackage

>>> rtl/pulse_low_time_trimmed_mean_core.sv
// Pulse low-time meter: phase tracking, duration ring and trimmed mean in Q4.
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    s_tdata[0] pin_level, one sample per tick
// m_*       out  m_tvalid/m_tready    status, duration_ticks, average_q4, valid_count
// cfg_*     in   cfg_valid/cfg_ready  cfg_data = timeout_ticks
//
// A sample passes IDLE and EVAL; a timeout result also passes EMIT, plus any wait for the output
// register. A finished pulse passes EVAL, WALK, PREP, DIV and EMIT, or skips DIV
// with fewer than three valid entries: one ring entry per cycle through
// the sum/min/max walk, then one quotient bit per cycle from the restoring
// divider. s_tready is high only in IDLE.
// Reset clears phase, counters and valid bits; ring contents need none.
// A result waiting in the output register does not stop new samples.
module pulse_low_time_trimmed_mean_core
	import pltm_pkg::*;
#(
	parameter int unsigned WINDOW        = 10,
	parameter int unsigned DURATION_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_TDATA_W-1:0]   s_tdata,   // [0] pin_level, [7:1] zero
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_TDATA_W-1:0]   m_tdata,   // [2:0] status, [26:3] duration_ticks,
	                                          // [54:27] average_q4, [58:55] valid_count
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [TIMEOUT_W-1:0]   cfg_data
);

	localparam int unsigned IW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CW   = $clog2(WINDOW + 1);
	localparam int unsigned DW   = $clog2(WINDOW);
	localparam int unsigned SUMW = DURATION_BITS + $clog2(WINDOW);
	localparam int unsigned QW   = SUMW + FRAC_BITS;
	localparam int unsigned DCW  = $clog2(QW);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_PREP = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0]               state_q;
	logic [TIMEOUT_W-1:0]     timeout_q;
	phase_t                   phase_q;
	logic [DURATION_BITS-1:0] ticks_q;
	logic [DURATION_BITS-1:0] ring_q [WINDOW];
	logic [WINDOW-1:0]        valid_q;
	logic [CW-1:0]            nvalid_q;
	logic [IW-1:0]            widx_q;
	logic                     pin_q;

	logic [IW-1:0]            walk_idx_q;
	logic                     first_q;
	logic [SUMW-1:0]          sum_q;
	logic [DURATION_BITS-1:0] min_q;
	logic [DURATION_BITS-1:0] max_q;

	logic [QW-1:0]            dvd_q;
	logic [DW-1:0]            rem_q;
	logic [DW-1:0]            divisor_q;
	logic [DCW-1:0]           div_cnt_q;

	status_t                  res_status_q;
	logic [DUR_OUT_W-1:0]     res_dur_q;
	logic [AVG_OUT_W-1:0]     res_avg_q;
	logic [COUNT_W-1:0]       res_cnt_q;

	logic                     m_valid_q;
	logic [M_TDATA_W-1:0]     m_data_q;

	// combinational helpers
	logic [DURATION_BITS-1:0] ticks_inc;
	logic [TIMEOUT_W-1:0]     timeout_eff;
	logic                     timed_out;
	logic [31:0]              ticks_ext;
	logic [7:0]               nvalid_ext;
	logic [COUNT_W-1:0]       cnt_sat;
	logic [DURATION_BITS-1:0] walk_val;
	logic                     walk_hit;
	logic [DW:0]              trial;
	logic                     trial_ge;
	logic [QW-1:0]            trimmed;
	logic [63:0]              quot_ext;
	logic                     out_free;

	assign ticks_inc   = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
	assign timeout_eff = (timeout_q == '0) ? TIMEOUT_W'(1) : timeout_q;
	assign timed_out   = 32'(ticks_inc) >= 32'(timeout_eff);
	assign ticks_ext   = 32'(ticks_q);
	assign nvalid_ext  = 8'(nvalid_q);
	assign cnt_sat     = (nvalid_ext > 8'd15) ? '1 : nvalid_ext[COUNT_W-1:0];

	assign walk_val = ring_q[walk_idx_q];
	assign walk_hit = valid_q[walk_idx_q];

	assign trial    = {rem_q, dvd_q[QW-1]};
	assign trial_ge = trial >= {1'b0, divisor_q};
	assign trimmed  = {sum_q - SUMW'(min_q) - SUMW'(max_q), FRAC_BITS'(0)};
	assign quot_ext = 64'(dvd_q);

	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	// control path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			timeout_q <= TIMEOUT_RESET;
			phase_q   <= PH_WAIT_HIGH;
			ticks_q   <= '0;
			valid_q   <= '0;
			nvalid_q  <= '0;
			widx_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			if (state_q == S_EMIT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					case (phase_q)
						PH_WAIT_FALL: begin
							if (!pin_q) begin
								phase_q <= PH_COUNT_LOW;
								ticks_q <= DURATION_BITS'(1);
								state_q <= S_IDLE;
							end else if (timed_out) begin
								phase_q <= PH_WAIT_HIGH;
								ticks_q <= '0;
								state_q <= S_EMIT;
							end else begin
								ticks_q <= ticks_inc;
								state_q <= S_IDLE;
							end
						end
						PH_COUNT_LOW: begin
							if (pin_q) begin
								valid_q[widx_q] <= 1'b1;
								if (!valid_q[widx_q]) begin
									nvalid_q <= nvalid_q + 1'b1;
								end
								widx_q  <= (widx_q == IW'(WINDOW - 1)) ? '0 : widx_q + 1'b1;
								phase_q <= PH_WAIT_HIGH;
								ticks_q <= '0;
								state_q <= S_WALK;
							end else if (timed_out) begin
								phase_q <= PH_WAIT_HIGH;
								ticks_q <= '0;
								state_q <= S_EMIT;
							end else begin
								ticks_q <= ticks_inc;
								state_q <= S_IDLE;
							end
						end
						default: begin
							// idle code and the unused code both wait for the first high
							if (pin_q) begin
								phase_q <= PH_WAIT_FALL;
								ticks_q <= '0;
								state_q <= S_IDLE;
							end else if (timed_out) begin
								phase_q <= PH_WAIT_HIGH;
								ticks_q <= '0;
								state_q <= S_EMIT;
							end else begin
								ticks_q <= ticks_inc;
								state_q <= S_IDLE;
							end
						end
					endcase
				end
				S_WALK: begin
					if (walk_idx_q == IW'(WINDOW - 1)) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= (nvalid_q < CW'(MIN_VALID)) ? S_EMIT : S_DIV;
				end
				S_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ring storage
	always_ff @(posedge clk) begin
		if (state_q == S_EVAL && phase_q == PH_COUNT_LOW && pin_q) begin
			ring_q[widx_q] <= ticks_q;
		end
	end

	// datapath: sample, walk, divider, result and output registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			pin_q <= s_tdata[0];
		end

		if (state_q == S_EVAL) begin
			res_avg_q  <= '0;
			res_dur_q  <= (phase_q == PH_COUNT_LOW && pin_q) ? ticks_ext[DUR_OUT_W-1:0] : '0;
			res_cnt_q  <= cnt_sat;
			walk_idx_q <= '0;
			first_q    <= 1'b1;
			sum_q      <= '0;
			case (phase_q)
				PH_WAIT_FALL: res_status_q <= ST_TO_FALL;
				PH_COUNT_LOW: res_status_q <= ST_TO_LOW;
				default:      res_status_q <= ST_TO_HIGH;
			endcase
		end

		if (state_q == S_WALK) begin
			walk_idx_q <= walk_idx_q + 1'b1;
			if (walk_hit) begin
				first_q <= 1'b0;
				sum_q   <= sum_q + SUMW'(walk_val);
				if (first_q || walk_val < min_q) begin
					min_q <= walk_val;
				end
				if (first_q || walk_val > max_q) begin
					max_q <= walk_val;
				end
			end
		end

		if (state_q == S_PREP) begin
			res_cnt_q <= cnt_sat;
			if (nvalid_q < CW'(MIN_VALID)) begin
				res_status_q <= ST_TOO_FEW;
			end else begin
				res_status_q <= ST_AVG_OK;
			end
			dvd_q     <= trimmed;
			rem_q     <= '0;
			divisor_q <= DW'(nvalid_q - CW'(2));
			div_cnt_q <= DCW'(QW - 1);
		end

		// restoring divide, one quotient bit per cycle
		if (state_q == S_DIV) begin
			rem_q     <= trial_ge ? DW'(trial - {1'b0, divisor_q}) : trial[DW-1:0];
			dvd_q     <= {dvd_q[QW-2:0], trial_ge};
			div_cnt_q <= div_cnt_q - 1'b1;
		end

		if (state_q == S_EMIT && res_status_q == ST_AVG_OK) begin
			res_avg_q <= (|quot_ext[63:AVG_OUT_W]) ? '1 : quot_ext[AVG_OUT_W-1:0];
		end

		if (state_q == S_EMIT && out_free) begin
			m_data_q <= {5'd0, res_cnt_q,
				((res_status_q == ST_AVG_OK)
					? ((|quot_ext[63:AVG_OUT_W]) ? {AVG_OUT_W{1'b1}}
					                              : quot_ext[AVG_OUT_W-1:0])
					: res_avg_q),
				res_dur_q, res_status_q};
		end
	end

endmodule
